// File: hdl/m3i_pkg.sv
// Shared types, widths and constants of the 3x3 matrix inverse.
package m3i_pkg;

    localparam int ELEM_BITS = 16;
    localparam int FRAC_BITS = 8;
    localparam int PROD_BITS = 2 * ELEM_BITS;
    localparam int ADJ_BITS  = PROD_BITS + 1;
    localparam int TERM_BITS = ADJ_BITS + ELEM_BITS;
    localparam int DET_BITS  = TERM_BITS + 2;
    localparam int NUM_BITS  = ADJ_BITS + 2 * FRAC_BITS;
    localparam int QUO_BITS  = ELEM_BITS + 1;
    localparam int DOUT_BITS = 2 * ELEM_BITS;
    localparam int NUM_ELEM  = 9;

    typedef logic signed [ELEM_BITS-1:0] elem_t;
    typedef elem_t [NUM_ELEM-1:0] mat_t;
    typedef logic signed [ADJ_BITS-1:0] adj_t;
    typedef adj_t [NUM_ELEM-1:0] adj_mat_t;
    typedef logic signed [DET_BITS-1:0] det_t;
    typedef logic [DET_BITS-1:0] mag_t;
    typedef logic [QUO_BITS-1:0] quo_t;

    typedef struct packed {
        logic signed [15:0] in_c0_r0;
        logic signed [15:0] in_c0_r1;
        logic signed [15:0] in_c0_r2;
        logic signed [15:0] in_c1_r0;
        logic signed [15:0] in_c1_r1;
        logic signed [15:0] in_c1_r2;
        logic signed [15:0] in_c2_r0;
        logic signed [15:0] in_c2_r1;
        logic signed [15:0] in_c2_r2;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_c0_r0;
        logic signed [15:0] out_c0_r1;
        logic signed [15:0] out_c0_r2;
        logic signed [15:0] out_c1_r0;
        logic signed [15:0] out_c1_r1;
        logic signed [15:0] out_c1_r2;
        logic signed [15:0] out_c2_r0;
        logic signed [15:0] out_c2_r1;
        logic signed [15:0] out_c2_r2;
        logic signed [31:0] determinant;
        logic               singular;
    } out_item_t;

endpackage

// File: hdl/m3i_adjugate.sv
// Four-stage pipeline forming the adjugate terms and the determinant.
module m3i_adjugate (
    input  logic            clk,
    input  logic            en,
    input  m3i_pkg::mat_t   m,
    output m3i_pkg::adj_mat_t adj,
    output m3i_pkg::det_t   det
);
    import m3i_pkg::*;

    logic signed [PROD_BITS-1:0] pa_reg [NUM_ELEM];
    logic signed [PROD_BITS-1:0] pb_reg [NUM_ELEM];
    elem_t    m1_reg [3];
    elem_t    m2_reg [3];
    adj_mat_t adj2_reg;
    adj_mat_t adj3_reg;
    adj_mat_t adj4_reg;
    logic signed [TERM_BITS-1:0] t_reg [3];
    det_t     det_reg;

    // Each adjugate term is a*b - c*d; the first products are registered alone.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg[0] <= m[4] * m[8];  pb_reg[0] <= m[7] * m[5];
            pa_reg[1] <= m[7] * m[2];  pb_reg[1] <= m[1] * m[8];
            pa_reg[2] <= m[1] * m[5];  pb_reg[2] <= m[4] * m[2];
            pa_reg[3] <= m[6] * m[5];  pb_reg[3] <= m[3] * m[8];
            pa_reg[4] <= m[0] * m[8];  pb_reg[4] <= m[6] * m[2];
            pa_reg[5] <= m[3] * m[2];  pb_reg[5] <= m[0] * m[5];
            pa_reg[6] <= m[3] * m[7];  pb_reg[6] <= m[6] * m[4];
            pa_reg[7] <= m[6] * m[1];  pb_reg[7] <= m[0] * m[7];
            pa_reg[8] <= m[0] * m[4];  pb_reg[8] <= m[3] * m[1];
            m1_reg <= '{m[0], m[1], m[2]};
            m2_reg <= m1_reg;
            for (int i = 0; i < NUM_ELEM; i++)
            begin
                adj2_reg[i] <= ADJ_BITS'(pa_reg[i]) - ADJ_BITS'(pb_reg[i]);
            end
            // The determinant expands along column zero, reusing the adjugate.
            t_reg[0] <= TERM_BITS'(m2_reg[0]) * TERM_BITS'(adj2_reg[0]);
            t_reg[1] <= TERM_BITS'(m2_reg[1]) * TERM_BITS'(adj2_reg[3]);
            t_reg[2] <= TERM_BITS'(m2_reg[2]) * TERM_BITS'(adj2_reg[6]);
            adj3_reg <= adj2_reg;
            det_reg  <= DET_BITS'(t_reg[0]) + DET_BITS'(t_reg[1]) + DET_BITS'(t_reg[2]);
            adj4_reg <= adj3_reg;
        end
    end

    assign adj = adj4_reg;
    assign det = det_reg;

endmodule

// File: hdl/m3i_divider.sv
// Pipelined restoring divider for magnitudes, one quotient bit per stage.
module m3i_divider (
    input  logic          clk,
    input  logic          en,
    input  m3i_pkg::mag_t num,
    input  m3i_pkg::mag_t den,
    output m3i_pkg::quo_t quo,
    output logic          ovf
);
    import m3i_pkg::*;

    mag_t rem_reg [QUO_BITS+1];
    mag_t den_reg [QUO_BITS+1];
    quo_t q_reg   [QUO_BITS+1];
    logic ovf_reg [QUO_BITS+1];

    // The first stage flags quotients too large for the quotient width.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num >> QUO_BITS) >= den;
        end
    end

    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_step
        localparam int K = QUO_BITS - 1 - j;
        logic fits;
        quo_t q_next;
        assign fits = (rem_reg[j] >> K) >= den_reg[j];
        always_comb
        begin
            q_next    = q_reg[j];
            q_next[K] = fits;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= fits ? rem_reg[j] - (den_reg[j] << K) : rem_reg[j];
                den_reg[j+1] <= den_reg[j];
                q_reg[j+1]   <= q_next;
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign quo = q_reg[QUO_BITS];
    assign ovf = ovf_reg[QUO_BITS];

endmodule

// File: hdl/matrix3_inverse.sv
// Top level of the pipelined 3x3 fixed-point matrix inverse.
// Throughput: one matrix per cycle while the output is not stalled; the 18-stage divider sets the depth.
// A stalled output holds the whole pipeline, so nothing is lost or repeated.
// Reset clears only the valid bits; the block is ready right after reset.
module matrix3_inverse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  m3i_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output m3i_pkg::out_item_t out_data
);
    import m3i_pkg::*;

    // Stage map: 0..3 adjugate, 4 prepare, 5..22 divider, 23 output.
    localparam int ADJ_LAT  = 4;
    localparam int DIV_LAT  = QUO_BITS + 1;
    localparam int PREP_IDX = ADJ_LAT;
    localparam int LAST_DIV = PREP_IDX + DIV_LAT;
    localparam int NSTAGE   = LAST_DIV + 2;

    logic [NSTAGE-1:0] v_reg;
    logic              en;
    mat_t              m_in;
    adj_mat_t          adj;
    det_t              det;

    // The whole pipeline moves together whenever the output can take a word.
    assign en        = !v_reg[NSTAGE-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NSTAGE-2:0], in_valid};
        end
    end

    assign m_in = {in_data.in_c2_r2, in_data.in_c2_r1, in_data.in_c2_r0,
                   in_data.in_c1_r2, in_data.in_c1_r1, in_data.in_c1_r0,
                   in_data.in_c0_r2, in_data.in_c0_r1, in_data.in_c0_r0};

    m3i_adjugate u_adj (
        .clk (clk),
        .en  (en),
        .m   (m_in),
        .adj (adj),
        .det (det)
    );

    // The input matrix rides along for the singular pass-through.
    mat_t mat_reg [LAST_DIV+1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg[0] <= m_in;
            for (int i = 1; i <= LAST_DIV; i++)
            begin
                mat_reg[i] <= mat_reg[i-1];
            end
        end
    end

    // Prepare stage: magnitudes and signs for the divider, the scaled determinant.
    localparam det_t DMAX = det_t'({1'b0, {(DOUT_BITS-1){1'b1}}});
    localparam det_t DMIN = -DMAX - det_t'(1);

    logic [NUM_ELEM-1:0] neg_next;
    mag_t                num_mag_next [NUM_ELEM];
    mag_t                den_mag_next;
    det_t                det_sh;
    logic [DOUT_BITS-1:0] dout_next;

    always_comb
    begin
        logic signed [NUM_BITS-1:0] num;
        den_mag_next = det[DET_BITS-1] ? mag_t'(-det) : mag_t'(det);
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            num = NUM_BITS'(adj[i]) <<< (2 * FRAC_BITS);
            num_mag_next[i] = num[NUM_BITS-1] ? DET_BITS'(-num) : DET_BITS'(num);
            neg_next[i] = num[NUM_BITS-1] ^ det[DET_BITS-1];
        end
        det_sh = det >>> FRAC_BITS;
        if (det_sh > DMAX)
        begin
            dout_next = DMAX[DOUT_BITS-1:0];
        end
        else if (det_sh < DMIN)
        begin
            dout_next = DMIN[DOUT_BITS-1:0];
        end
        else
        begin
            dout_next = det_sh[DOUT_BITS-1:0];
        end
    end

    mag_t                 num_mag_reg [NUM_ELEM];
    mag_t                 den_mag_reg;
    logic [NUM_ELEM-1:0]  neg_reg  [DIV_LAT+1];
    logic                 zero_reg [DIV_LAT+1];
    logic [DOUT_BITS-1:0] dout_reg [DIV_LAT+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_mag_reg <= num_mag_next;
            den_mag_reg <= den_mag_next;
            neg_reg[0]  <= neg_next;
            zero_reg[0] <= (det == '0);
            dout_reg[0] <= dout_next;
            for (int i = 1; i <= DIV_LAT; i++)
            begin
                neg_reg[i]  <= neg_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                dout_reg[i] <= dout_reg[i-1];
            end
        end
    end

    // Nine divider lanes share the determinant magnitude.
    quo_t                quo [NUM_ELEM];
    logic [NUM_ELEM-1:0] ovf;

    for (genvar i = 0; i < NUM_ELEM; i++)
    begin : g_lane
        m3i_divider u_div (
            .clk (clk),
            .en  (en),
            .num (num_mag_reg[i]),
            .den (den_mag_reg),
            .quo (quo[i]),
            .ovf (ovf[i])
        );
    end

    // Output stage: apply the sign, saturate, or pass a singular matrix through.
    localparam quo_t QPOS = quo_t'({1'b0, {(ELEM_BITS-1){1'b1}}});
    localparam quo_t QNEG = QPOS + quo_t'(1);
    localparam elem_t EMAX = elem_t'(QPOS);
    localparam elem_t EMIN = elem_t'(QNEG);

    mat_t res;
    always_comb
    begin
        quo_t nq;
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            nq = -quo[i];
            if (zero_reg[DIV_LAT])
            begin
                res[i] = mat_reg[LAST_DIV][i];
            end
            else if (!neg_reg[DIV_LAT][i])
            begin
                res[i] = (ovf[i] || quo[i] > QPOS) ? EMAX : quo[i][ELEM_BITS-1:0];
            end
            else
            begin
                res[i] = (ovf[i] || quo[i] > QNEG) ? EMIN : nq[ELEM_BITS-1:0];
            end
        end
    end

    out_item_t out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.out_c0_r0   <= res[0];
            out_reg.out_c0_r1   <= res[1];
            out_reg.out_c0_r2   <= res[2];
            out_reg.out_c1_r0   <= res[3];
            out_reg.out_c1_r1   <= res[4];
            out_reg.out_c1_r2   <= res[5];
            out_reg.out_c2_r0   <= res[6];
            out_reg.out_c2_r1   <= res[7];
            out_reg.out_c2_r2   <= res[8];
            out_reg.determinant <= zero_reg[DIV_LAT] ? '0 : dout_reg[DIV_LAT];
            out_reg.singular    <= zero_reg[DIV_LAT];
        end
    end

    assign out_data = out_reg;

endmodule
